### hdl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/cisc_pkg.sv
// ----------------------------------------------------------------------------
// cisc_pkg
// Types, bus codes, step codes and opcodes of the instruction subset core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cisc_pkg;

    // bus operation codes
    localparam logic [2:0] BUS_MRD  = 3'd0;
    localparam logic [2:0] BUS_MWR  = 3'd1;
    localparam logic [2:0] BUS_PWR  = 3'd2;
    localparam logic [2:0] BUS_PRD  = 3'd3;
    localparam logic [2:0] BUS_DONE = 3'd4;

    // decode step codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_OPC   = 3'd1;
    localparam logic [2:0] PH_IMM1  = 3'd2;
    localparam logic [2:0] PH_IMM2  = 3'd3;
    localparam logic [2:0] PH_DATA1 = 3'd4;
    localparam logic [2:0] PH_DATA2 = 3'd5;
    localparam logic [2:0] PH_PORT  = 3'd6;

    // request kinds
    localparam logic REQ_BEGIN = 1'b0;

    // opcodes
    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_LD_A_N   = 8'h3E;
    localparam logic [7:0] OP_JR       = 8'h18;
    localparam logic [7:0] OP_JR_NZ    = 8'h20;
    localparam logic [7:0] OP_JR_Z     = 8'h28;
    localparam logic [7:0] OP_JR_NC    = 8'h30;
    localparam logic [7:0] OP_JR_C     = 8'h38;
    localparam logic [7:0] OP_OUT      = 8'hD3;
    localparam logic [7:0] OP_LD_HL_N  = 8'h36;
    localparam logic [7:0] OP_DJNZ     = 8'h10;
    localparam logic [7:0] OP_CP_N     = 8'hFE;
    localparam logic [7:0] OP_IN       = 8'hDB;
    localparam logic [7:0] OP_ST_A     = 8'h32;
    localparam logic [7:0] OP_LD_HL_NN = 8'h21;
    localparam logic [7:0] OP_LD_DE_NN = 8'h11;
    localparam logic [7:0] OP_LD_BC_NN = 8'h01;
    localparam logic [7:0] OP_JP       = 8'hC3;
    localparam logic [7:0] OP_CALL     = 8'hCD;
    localparam logic [7:0] OP_ST_HL    = 8'h22;
    localparam logic [7:0] OP_LD_HL_M  = 8'h2A;
    localparam logic [7:0] OP_CALL_NZ  = 8'hC4;
    localparam logic [7:0] OP_CALL_Z   = 8'hCC;
    localparam logic [7:0] OP_LD_A_HL  = 8'h7E;
    localparam logic [7:0] OP_CP_HL    = 8'hBE;
    localparam logic [7:0] OP_RET      = 8'hC9;
    localparam logic [7:0] OP_RET_NZ   = 8'hC0;
    localparam logic [7:0] OP_RET_Z    = 8'hC8;
    localparam logic [7:0] OP_ST_HL_A  = 8'h77;
    localparam logic [7:0] OP_INC_HL   = 8'h23;
    localparam logic [7:0] OP_INC_DE   = 8'h13;
    localparam logic [7:0] OP_DEC_BC   = 8'h0B;
    localparam logic [7:0] OP_XOR_A    = 8'hAF;
    localparam logic [7:0] OP_INC_A    = 8'h3C;
    localparam logic [7:0] OP_DEC_A    = 8'h3D;
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_EI       = 8'hFB;
    localparam logic [7:0] OP_DI       = 8'hF3;
    localparam logic [7:0] OP_RST38    = 8'hFF;

    localparam logic [15:0] RST_VEC = 16'h0038;
    localparam logic [7:0]  IO_PORT_RST = 8'hFE;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a;
        logic [7:0]  f;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic        ie;
        logic [7:0]  opc;
        logic [2:0]  phase;
        logic [7:0]  opl;
        logic [15:0] oaddr;
    } t_arch;

    // state after reset
    localparam t_arch ARCH_RST = '{pc: 16'h0000, sp: 16'hFFFF, a: 8'h00, f: 8'h00,
                                   bc: 16'h0000, de: 16'h0000, hl: 16'h0000,
                                   ie: 1'b0, opc: 8'h00, phase: PH_IDLE,
                                   opl: 8'h00, oaddr: 16'h0000};

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_result;

    function automatic t_result mk_res(logic [2:0] op, logic [15:0] addr,
                                       logic [7:0] wdata);
        t_result r;
        r.op    = op;
        r.addr  = addr;
        r.wdata = wdata;
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/cisc_exec.sv
// ----------------------------------------------------------------------------
// cisc_exec
// One decode step: current state plus one request gives next state and up
// to three bus results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cisc_exec (
    input  cisc_pkg::t_arch         i_state,
    input  logic                    i_req_type,
    input  logic [7:0]              i_data,
    input  logic [7:0]              i_io_port,
    output cisc_pkg::t_arch         o_state,
    output cisc_pkg::t_result [2:0] o_res,
    output logic [1:0]              o_cnt
);
    import cisc_pkg::*;

    t_arch             s;
    t_result [2:0]     res;
    logic [1:0]        cnt;
    logic              zf;
    logic [15:0]       word;
    logic [15:0]       rel;
    logic [7:0]        b_dec;

    always_comb begin
        s     = i_state;
        res   = '0;
        cnt   = 2'd0;
        zf    = i_state.f[0];
        word  = {i_data, i_state.opl};
        rel   = i_state.pc + {{8{i_data[7]}}, i_data};
        b_dec = i_state.bc[15:8] - 8'd1;
        if (i_req_type == REQ_BEGIN) begin
            s.phase = PH_OPC;
            res[0]  = mk_res(BUS_MRD, s.pc, 8'd0);
            cnt     = 2'd1;
            s.pc    = s.pc + 16'd1;
        end else begin
            unique case (i_state.phase)
                PH_OPC: begin
                    s.opc = i_data;
                    unique case (i_data)
                        OP_LD_A_N, OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C,
                        OP_OUT, OP_LD_HL_N, OP_DJNZ, OP_CP_N, OP_IN, OP_ST_A,
                        OP_LD_HL_NN, OP_LD_DE_NN, OP_LD_BC_NN, OP_JP, OP_CALL,
                        OP_ST_HL, OP_LD_HL_M, OP_CALL_NZ, OP_CALL_Z: begin
                            s.phase = PH_IMM1;
                            res[0]  = mk_res(BUS_MRD, s.pc, 8'd0);
                            cnt     = 2'd1;
                            s.pc    = s.pc + 16'd1;
                        end
                        OP_LD_A_HL, OP_CP_HL: begin
                            s.phase = PH_DATA1;
                            res[0]  = mk_res(BUS_MRD, s.hl, 8'd0);
                            cnt     = 2'd1;
                        end
                        OP_RET, OP_RET_NZ, OP_RET_Z: begin
                            if ((i_data == OP_RET) || (i_data == OP_RET_NZ && !zf)
                                || (i_data == OP_RET_Z && zf)) begin
                                s.phase = PH_DATA1;
                                res[0]  = mk_res(BUS_MRD, s.sp, 8'd0);
                                cnt     = 2'd1;
                                s.sp    = s.sp + 16'd1;
                            end
                        end
                        OP_ST_HL_A: begin
                            res[0] = mk_res(BUS_MWR, s.hl, s.a);
                            cnt    = 2'd1;
                        end
                        OP_INC_HL: s.hl = s.hl + 16'd1;
                        OP_INC_DE: s.de = s.de + 16'd1;
                        OP_DEC_BC: s.bc = s.bc - 16'd1;
                        OP_XOR_A:  s.a  = 8'd0;
                        OP_INC_A:  s.a  = s.a + 8'd1;
                        OP_DEC_A:  s.a  = s.a - 8'd1;
                        OP_HALT:   s.pc = s.pc - 16'd1;
                        OP_EI:     s.ie = 1'b1;
                        OP_DI:     s.ie = 1'b0;
                        OP_RST38: begin
                            s.sp   = s.sp - 16'd2;
                            res[0] = mk_res(BUS_MWR, s.sp, s.pc[7:0]);
                            res[1] = mk_res(BUS_MWR, s.sp + 16'd1, s.pc[15:8]);
                            cnt    = 2'd2;
                            s.pc   = RST_VEC;
                        end
                        default: ;
                    endcase
                end
                PH_IMM1: begin
                    unique case (i_state.opc)
                        OP_LD_A_N: s.a = i_data;
                        OP_JR:     s.pc = rel;
                        OP_JR_NZ, OP_JR_NC: if (!zf) s.pc = rel;
                        OP_JR_Z, OP_JR_C:   if (zf) s.pc = rel;
                        OP_DJNZ: begin
                            s.bc[15:8] = b_dec;
                            if (b_dec != 8'd0) s.pc = rel;
                        end
                        OP_CP_N: s.f[0] = (s.a == i_data);
                        OP_LD_HL_N: begin
                            res[0] = mk_res(BUS_MWR, s.hl, i_data);
                            cnt    = 2'd1;
                        end
                        OP_OUT: begin
                            if (i_data == i_io_port) begin
                                res[0] = mk_res(BUS_PWR, {8'd0, i_data}, s.a);
                                cnt    = 2'd1;
                            end
                        end
                        OP_IN: begin
                            if (i_data == i_io_port) begin
                                s.phase = PH_PORT;
                                res[0]  = mk_res(BUS_PRD, {8'd0, i_data}, 8'd0);
                                cnt     = 2'd1;
                            end else begin
                                s.a = 8'hFF;
                            end
                        end
                        default: begin
                            s.opl   = i_data;
                            s.phase = PH_IMM2;
                            res[0]  = mk_res(BUS_MRD, s.pc, 8'd0);
                            cnt     = 2'd1;
                            s.pc    = s.pc + 16'd1;
                        end
                    endcase
                end
                PH_IMM2: begin
                    unique case (i_state.opc)
                        OP_ST_A: begin
                            res[0] = mk_res(BUS_MWR, word, s.a);
                            cnt    = 2'd1;
                        end
                        OP_LD_HL_NN: s.hl = word;
                        OP_LD_DE_NN: s.de = word;
                        OP_LD_BC_NN: s.bc = word;
                        OP_JP:       s.pc = word;
                        OP_CALL, OP_CALL_NZ, OP_CALL_Z: begin
                            if ((i_state.opc == OP_CALL)
                                || (i_state.opc == OP_CALL_NZ && !zf)
                                || (i_state.opc == OP_CALL_Z && zf)) begin
                                s.sp   = s.sp - 16'd2;
                                res[0] = mk_res(BUS_MWR, s.sp, s.pc[7:0]);
                                res[1] = mk_res(BUS_MWR, s.sp + 16'd1, s.pc[15:8]);
                                cnt    = 2'd2;
                                s.pc   = word;
                            end
                        end
                        OP_ST_HL: begin
                            res[0] = mk_res(BUS_MWR, word, s.hl[7:0]);
                            res[1] = mk_res(BUS_MWR, word + 16'd1, s.hl[15:8]);
                            cnt    = 2'd2;
                        end
                        OP_LD_HL_M: begin
                            s.oaddr = word;
                            s.phase = PH_DATA1;
                            res[0]  = mk_res(BUS_MRD, word, 8'd0);
                            cnt     = 2'd1;
                        end
                        default: ;
                    endcase
                end
                PH_DATA1: begin
                    unique case (i_state.opc)
                        OP_LD_A_HL: s.a = i_data;
                        OP_CP_HL:   s.f[0] = (s.a == i_data);
                        OP_RET, OP_RET_NZ, OP_RET_Z: begin
                            s.opl   = i_data;
                            s.phase = PH_DATA2;
                            res[0]  = mk_res(BUS_MRD, s.sp, 8'd0);
                            cnt     = 2'd1;
                            s.sp    = s.sp + 16'd1;
                        end
                        OP_LD_HL_M: begin
                            s.opl   = i_data;
                            s.phase = PH_DATA2;
                            res[0]  = mk_res(BUS_MRD, s.oaddr + 16'd1, 8'd0);
                            cnt     = 2'd1;
                        end
                        default: ;
                    endcase
                end
                PH_DATA2: begin
                    if (i_state.opc == OP_LD_HL_M) s.hl = word;
                    else s.pc = word;
                end
                PH_PORT: s.a = i_data;
                default: s.phase = PH_IDLE;
            endcase
            // steps that issue no further read finish the instruction
            if (i_state.phase != PH_IDLE && s.phase == i_state.phase
                && !(i_state.phase == PH_DATA1 && s.phase == PH_DATA1 && cnt != 2'd0
                     && res[cnt - 2'd1].op == BUS_MRD)) begin
                s.phase  = PH_IDLE;
                res[cnt] = mk_res(BUS_DONE, 16'd0, 8'd0);
                cnt      = cnt + 2'd1;
            end else if (i_state.phase != PH_IDLE
                         && (cnt == 2'd0 || res[cnt - 2'd1].op == BUS_MWR
                             || res[cnt - 2'd1].op == BUS_PWR)) begin
                s.phase  = PH_IDLE;
                res[cnt] = mk_res(BUS_DONE, 16'd0, 8'd0);
                cnt      = cnt + 2'd1;
            end
        end
        o_state = s;
        o_res   = res;
        o_cnt   = cnt;
    end

endmodule
`default_nettype wire

### hdl/cpu_instruction_subset_core.sv
// ----------------------------------------------------------------------------
// cpu_instruction_subset_core
// Bus-driven 8-bit CPU core for a small instruction subset.
// ----------------------------------------------------------------------------
// Usage:
//  Requests enter on the s channel: tuser is the kind (0 begin the next
//  instruction, 1 read data returning), tdata the returned byte. Each request
//  yields zero to three results on the m channel (memory/port writes, then a
//  memory/port read or a finish word); tlast marks the last one of a request.
//  A request is decoded in the cycle it is accepted and its first result is
//  valid on the next cycle. Results leave one per cycle, while the receiver
//  is ready, from a three-entry result buffer; a request is taken whenever
//  that buffer holds at most one result that leaves in the same cycle, so one
//  request per cycle is sustained while each yields one result and the
//  receiver is ready.
//  While the receiver stalls, the buffered results wait and no new request is
//  taken. Reset (synchronous, active low) loads PC 0, SP FFFF, clears the
//  registers, empties the result buffer and sets the I/O port to FE.
//  The user writes io_port through i_cfg_we / i_cfg_wdata only while idle; the core does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpu_instruction_subset_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] read_data
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [2:0] bus_op, [18:3] bus_address,
                                     // [26:19] write_data, [42:27] prog_counter
    output logic        o_m_tlast
);
    import cisc_pkg::*;

    t_arch             r_st, n_st;
    t_result [2:0]     r_res, x_res;
    logic [1:0]        r_cnt, x_cnt;
    logic [15:0]       r_pc_out;
    logic [7:0]        r_io_port;
    logic              take, acc;

    cisc_exec u_exec (
        .i_state   (r_st),
        .i_req_type(i_s_tuser),
        .i_data    (i_s_tdata),
        .i_io_port (r_io_port),
        .o_state   (n_st),
        .o_res     (x_res),
        .o_cnt     (x_cnt)
    );

    // handshake
    assign take       = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_tready);
    assign acc        = i_s_tvalid && o_s_tready;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_io_port <= IO_PORT_RST;
        else if (i_cfg_we) r_io_port <= i_cfg_wdata;
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ARCH_RST;
        end else if (acc) begin
            r_st <= n_st;
        end
    end

    // result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (acc) begin
            r_cnt <= x_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res    <= x_res;
            r_pc_out <= n_st.pc;
        end else if (take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tlast  = (r_cnt == 2'd1);
    assign o_m_tdata  = {5'd0, r_pc_out, r_res[0].wdata, r_res[0].addr, r_res[0].op};

    `ASSERT_NEVER(a_no_accept_full, i_clk, i_rst_n, acc && r_cnt > 2'd1)
    `ASSERT_NEVER(a_phase_legal, i_clk, i_rst_n, r_st.phase == 3'd7)
    `ASSERT_CLK(a_drain, i_clk, i_rst_n,
        (take && r_cnt == 2'd1 && !acc) |=> !o_m_tvalid)
    `ASSERT_CLK(a_cnt_step, i_clk, i_rst_n,
        (take && r_cnt > 2'd1) |=> (r_cnt == $past(r_cnt) - 2'd1))

endmodule
`default_nettype wire

### tb/tb_cpu_instruction_subset_core.sv
// ----------------------------------------------------------------------------
// tb_cpu_instruction_subset_core
// Self-checking bench for the instruction subset core: drives begin and
// read-data requests, predicts the bus results, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_cpu_instruction_subset_core;
    import cisc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [15:0] pc;
        logic        last;
    } bus_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;

    cpu_instruction_subset_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predicted core state
    logic [7:0]  port_sel;
    logic [15:0] pc, sp, bc, de, hl, oaddr;
    logic [7:0]  acc, flags, opc, opl;
    logic        ie;
    logic [2:0]  phase;

    bus_result_t pending_bus_q[$];
    bus_result_t step_q[$];
    int  err_cnt = 0;
    int  stall_cnt = 0;
    int  sent_cnt = 0;
    bit  no_idle = 1'b0;
    bit  feeding = 1'b0;

    function automatic bit zf();
        return flags[0];
    endfunction

    function automatic void put(logic [2:0] op, logic [15:0] a, logic [7:0] d);
        bus_result_t r;
        r.op = op; r.addr = a; r.wdata = d; r.pc = '0; r.last = 1'b0;
        step_q.push_back(r);
    endfunction

    function automatic void done();
        phase = PH_IDLE;
        put(BUS_DONE, 16'h0, 8'h0);
    endfunction

    function automatic void fetch_pc();
        put(BUS_MRD, pc, 8'h0);
        pc = pc + 16'd1;
    endfunction

    function automatic void pop_sp();
        put(BUS_MRD, sp, 8'h0);
        sp = sp + 16'd1;
    endfunction

    function automatic void rel(logic [7:0] d);
        pc = pc + {{8{d[7]}}, d};
    endfunction

    function automatic void cmp(logic [7:0] n);
        flags[0] = (acc == n);
    endfunction

    function automatic void call_to(logic [15:0] tgt);
        sp = sp - 16'd2;
        put(BUS_MWR, sp, pc[7:0]);
        put(BUS_MWR, sp + 16'd1, pc[15:8]);
        pc = tgt;
        done();
    endfunction

    function automatic void predict_reset();
        port_sel = IO_PORT_RST;
        pc = '0; sp = 16'hFFFF; acc = '0; flags = '0;
        bc = '0; de = '0; hl = '0; ie = 1'b0;
        opc = '0; opl = '0; oaddr = '0; phase = PH_IDLE;
    endfunction

    // opcode byte returned after a fetch
    function automatic void decode_opcode(logic [7:0] op);
        opc = op;
        case (op)
            OP_LD_A_N, OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C, OP_OUT,
            OP_LD_HL_N, OP_DJNZ, OP_CP_N, OP_IN, OP_ST_A, OP_LD_HL_NN,
            OP_LD_DE_NN, OP_LD_BC_NN, OP_JP, OP_CALL, OP_ST_HL, OP_LD_HL_M,
            OP_CALL_NZ, OP_CALL_Z: begin
                phase = PH_IMM1; fetch_pc();
            end
            OP_LD_A_HL, OP_CP_HL: begin
                phase = PH_DATA1; put(BUS_MRD, hl, 8'h0);
            end
            OP_RET: begin
                phase = PH_DATA1; pop_sp();
            end
            OP_RET_NZ: begin
                if (!zf()) begin phase = PH_DATA1; pop_sp(); end else done();
            end
            OP_RET_Z: begin
                if (zf()) begin phase = PH_DATA1; pop_sp(); end else done();
            end
            OP_ST_HL_A: begin put(BUS_MWR, hl, acc); done(); end
            OP_INC_HL: begin hl = hl + 16'd1; done(); end
            OP_INC_DE: begin de = de + 16'd1; done(); end
            OP_DEC_BC: begin bc = bc - 16'd1; done(); end
            OP_XOR_A: begin acc = '0; done(); end
            OP_INC_A: begin acc = acc + 8'd1; done(); end
            OP_DEC_A: begin acc = acc - 8'd1; done(); end
            OP_HALT: begin pc = pc - 16'd1; done(); end
            OP_EI: begin ie = 1'b1; done(); end
            OP_DI: begin ie = 1'b0; done(); end
            OP_RST38: call_to(RST_VEC);
            default: done();
        endcase
    endfunction

    function automatic void decode_imm1(logic [7:0] d);
        logic [7:0] b;
        case (opc)
            OP_LD_A_N: begin acc = d; done(); end
            OP_JR: begin rel(d); done(); end
            OP_JR_NZ, OP_JR_NC: begin if (!zf()) rel(d); done(); end
            OP_JR_Z, OP_JR_C: begin if (zf()) rel(d); done(); end
            OP_DJNZ: begin
                b = bc[15:8] - 8'd1;
                bc[15:8] = b;
                if (b != 0) rel(d);
                done();
            end
            OP_CP_N: begin cmp(d); done(); end
            OP_LD_HL_N: begin put(BUS_MWR, hl, d); done(); end
            OP_OUT: begin
                if (d == port_sel) put(BUS_PWR, {8'h0, d}, acc);
                done();
            end
            OP_IN: begin
                if (d == port_sel) begin
                    phase = PH_PORT; put(BUS_PRD, {8'h0, d}, 8'h0);
                end else begin
                    acc = 8'hFF; done();
                end
            end
            default: begin opl = d; phase = PH_IMM2; fetch_pc(); end
        endcase
    endfunction

    function automatic void decode_imm2(logic [7:0] d);
        logic [15:0] a;
        a = {d, opl};
        case (opc)
            OP_ST_A: begin put(BUS_MWR, a, acc); done(); end
            OP_LD_HL_NN: begin hl = a; done(); end
            OP_LD_DE_NN: begin de = a; done(); end
            OP_LD_BC_NN: begin bc = a; done(); end
            OP_JP: begin pc = a; done(); end
            OP_CALL: call_to(a);
            OP_CALL_NZ: if (!zf()) call_to(a); else done();
            OP_CALL_Z: if (zf()) call_to(a); else done();
            OP_ST_HL: begin
                put(BUS_MWR, a, hl[7:0]);
                put(BUS_MWR, a + 16'd1, hl[15:8]);
                done();
            end
            OP_LD_HL_M: begin oaddr = a; phase = PH_DATA1; put(BUS_MRD, a, 8'h0); end
            default: done();
        endcase
    endfunction

    function automatic void decode_data1(logic [7:0] d);
        case (opc)
            OP_LD_A_HL: begin acc = d; done(); end
            OP_CP_HL: begin cmp(d); done(); end
            OP_RET, OP_RET_NZ, OP_RET_Z: begin opl = d; phase = PH_DATA2; pop_sp(); end
            OP_LD_HL_M: begin
                opl = d; phase = PH_DATA2; put(BUS_MRD, oaddr + 16'd1, 8'h0);
            end
            default: done();
        endcase
    endfunction

    // one request into the predicted core; results go to the expected queue
    function automatic void predict_request(logic kind, logic [7:0] d);
        step_q.delete();
        if (kind == REQ_BEGIN) begin
            phase = PH_OPC; fetch_pc();
        end else begin
            case (phase)
                PH_OPC: decode_opcode(d);
                PH_IMM1: decode_imm1(d);
                PH_IMM2: decode_imm2(d);
                PH_DATA1: decode_data1(d);
                PH_DATA2: begin
                    if (opc == OP_LD_HL_M) hl = {d, opl}; else pc = {d, opl};
                    done();
                end
                PH_PORT: begin acc = d; done(); end
                default: phase = PH_IDLE;
            endcase
        end
        foreach (step_q[k]) begin
            step_q[k].pc = pc;
            step_q[k].last = (k == step_q.size() - 1);
            pending_bus_q.push_back(step_q[k]);
        end
    endfunction

    // send one request and update the prediction on acceptance;
    // tvalid stays high into the next request unless an idle cycle comes
    task automatic send_request(logic kind, logic [7:0] d);
        while (!no_idle && $urandom_range(99) < 37) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_request(kind, d);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_bus_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_port(logic [7:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        port_sel = v;
    endtask

    task automatic run_instr(logic [7:0] op, logic [7:0] b1, logic [7:0] b2,
                             logic [7:0] b3, logic [7:0] b4);
        send_request(REQ_BEGIN, 8'($urandom));
        send_request(~REQ_BEGIN, op);
        if (phase != PH_IDLE) send_request(~REQ_BEGIN, b1);
        if (phase != PH_IDLE) send_request(~REQ_BEGIN, b2);
        if (phase != PH_IDLE) send_request(~REQ_BEGIN, b3);
        if (phase != PH_IDLE) send_request(~REQ_BEGIN, b4);
    endtask

    // result check
    always @(posedge i_clk) begin
        bus_result_t exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bus_q.size() == 0) begin
                $display("%0t: unexpected result %h last %b", $time, o_m_tdata, o_m_tlast);
                err_cnt++;
            end else begin
                exp_r = pending_bus_q.pop_front();
                if (o_m_tdata[2:0] !== exp_r.op || o_m_tdata[18:3] !== exp_r.addr ||
                    o_m_tdata[26:19] !== exp_r.wdata || o_m_tdata[42:27] !== exp_r.pc ||
                    o_m_tdata[47:43] !== 5'b0 || o_m_tlast !== exp_r.last) begin
                    $display("%0t: mismatch exp op %h addr %h wd %h pc %h last %b",
                             $time, exp_r.op, exp_r.addr, exp_r.wdata, exp_r.pc,
                             exp_r.last);
                    $display("%0t:          act op %h addr %h wd %h pc %h last %b",
                             $time, o_m_tdata[2:0], o_m_tdata[18:3],
                             o_m_tdata[26:19], o_m_tdata[42:27], o_m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= no_idle || ($urandom_range(99) >= 37);
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !feeding)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        run_instr(OP_LD_A_N, 8'h5A, 8'h00, 8'h00, 8'h00);
        run_instr(OP_CP_N, 8'h5A, 8'h00, 8'h00, 8'h00);
        run_instr(OP_JR_Z, 8'h80, 8'h00, 8'h00, 8'h00);
        run_instr(OP_JR_NZ, 8'h7F, 8'h00, 8'h00, 8'h00);
        run_instr(OP_LD_BC_NN, 8'h00, 8'h01, 8'h00, 8'h00);
        run_instr(OP_DJNZ, 8'h10, 8'h00, 8'h00, 8'h00);
        run_instr(OP_DEC_BC, 8'h00, 8'h00, 8'h00, 8'h00);
        run_instr(OP_LD_HL_NN, 8'hFF, 8'hFF, 8'h00, 8'h00);
        run_instr(OP_INC_HL, 8'h00, 8'h00, 8'h00, 8'h00);
        run_instr(OP_ST_HL, 8'hFF, 8'hFF, 8'h00, 8'h00);
        run_instr(OP_LD_HL_M, 8'hFF, 8'hFF, 8'h34, 8'h12);
        run_instr(OP_CALL, 8'h00, 8'h80, 8'h00, 8'h00);
        run_instr(OP_RET, 8'h10, 8'h00, 8'h00, 8'h00);
        run_instr(OP_RST38, 8'h00, 8'h00, 8'h00, 8'h00);
        run_instr(OP_HALT, 8'h00, 8'h00, 8'h00, 8'h00);
        run_instr(OP_IN, 8'hFE, 8'hA5, 8'h00, 8'h00);
        run_instr(OP_IN, 8'h01, 8'h00, 8'h00, 8'h00);
        run_instr(OP_OUT, 8'hFE, 8'h00, 8'h00, 8'h00);
        run_instr(OP_OUT, 8'h00, 8'h00, 8'h00, 8'h00);
        run_instr(8'hED, 8'h00, 8'h00, 8'h00, 8'h00);
        // response while idle, then a begin that abandons a fetch
        send_request(~REQ_BEGIN, 8'hFF);
        send_request(REQ_BEGIN, 8'h00);
        send_request(~REQ_BEGIN, OP_JP);
        send_request(REQ_BEGIN, 8'h00);
        send_request(~REQ_BEGIN, OP_NOP);
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [7:0] ops [37] = '{OP_LD_A_N, OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC,
            OP_JR_C, OP_OUT, OP_LD_HL_N, OP_DJNZ, OP_CP_N, OP_IN, OP_ST_A,
            OP_LD_HL_NN, OP_LD_DE_NN, OP_LD_BC_NN, OP_JP, OP_CALL, OP_ST_HL,
            OP_LD_HL_M, OP_CALL_NZ, OP_CALL_Z, OP_LD_A_HL, OP_CP_HL, OP_RET,
            OP_RET_NZ, OP_RET_Z, OP_ST_HL_A, OP_INC_HL, OP_INC_DE, OP_DEC_BC,
            OP_XOR_A, OP_INC_A, OP_DEC_A, OP_HALT, OP_EI, OP_DI, OP_RST38};
        if ($urandom_range(9) == 0) return 8'($urandom);
        return ops[$urandom_range(36)];
    endfunction

    // random byte, biased toward the configured port and the accumulator
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0: return port_sel;
            1: return acc;
            default: return 8'($urandom);
        endcase
    endfunction

    // sends about n_items requests
    task automatic test_random(int n_items);
        int stop_at;
        stop_at = sent_cnt + n_items;
        while (sent_cnt < stop_at) begin
            if ($urandom_range(15) == 0) begin
                // noise: stray response or abandoned instruction
                send_request(1'($urandom_range(1)), 8'($urandom));
            end else begin
                run_instr(pick_opcode(), pick_byte(), pick_byte(), pick_byte(),
                          pick_byte());
            end
        end
    endtask

    initial begin
        predict_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        feeding = 1'b1;
        test_directed();
        write_port(8'h00);
        run_instr(OP_OUT, 8'h00, 8'h00, 8'h00, 8'h00);
        run_instr(OP_IN, 8'h00, 8'h3C, 8'h00, 8'h00);
        test_random(110);
        write_port(8'hFF);
        test_random(110);
        // after draining, the sender sends with no idling and the receiver never stalls
        wait_drained();
        no_idle = 1'b1;
        test_random(70);
        no_idle = 1'b0;
        write_port(8'($urandom));
        test_random(110);
        wait_drained();
        repeat (10) @(posedge i_clk);
        feeding = 1'b0;
        if (err_cnt == 0 && pending_bus_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/cisc_pkg.sv
hdl/cisc_exec.sv
hdl/cpu_instruction_subset_core.sv
tb/tb_cpu_instruction_subset_core.sv
